// ----- src/gtsg_pkg.sv -----
// Shared types and constants for the trilinear grid sampler with gradient.
`default_nettype none

package gtsg_pkg;

  // Default store dimensions (cells along x, y and z).
  localparam int GRID_MAX_X_DEF = 32;
  localparam int GRID_MAX_Y_DEF = 32;
  localparam int GRID_MAX_Z_DEF = 32;

  // Fixed point format of positions and results.
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 13;
  localparam int IDX_W     = POS_W - FRAC_BITS;
  localparam int SAMPLE_W  = 16;
  localparam int CELL_W    = 5;

  // Stream word widths.
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 104;

  // Configuration port.
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = 2'd2;
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = 6'd32;

  // Item kinds carried in s_tuser.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DIFF,
    ST_PROD,
    ST_MIX,
    ST_DONE
  } gtsg_state_t;

endpackage : gtsg_pkg

`default_nettype wire

// ----- src/grid_trilinear_sample_gradient_core.sv -----
// Top level of the trilinear grid sampler with analytic gradient.
//
//   channel   dir  signals                              contents
//   s_*       in   s_tvalid s_tready s_tdata s_tuser    grid write or query word
//   m_*       out  m_tvalid m_tready m_tdata m_tuser    interpolated value and gradient
//   cfg_*     in   cfg_we cfg_index cfg_data            grid size registers
//
// A write word is stored on acceptance. An in-range query passes READ (eight corner reads
// on the single RAM port), LAST, DIFF, PROD and MIX and loads the result register in DONE
// (four arithmetic steps), then returns to IDLE for the next word. An out-of-range query
// goes straight to DONE. A finished result waits in the output register while the next
// word is accepted; a query whose result is ready holds while that register is still full.
// Reset (rst, synchronous) sets the size registers to 32 and clears control state only.
`default_nettype none

module grid_trilinear_sample_gradient_core #(
  parameter int GRID_MAX_X = gtsg_pkg::GRID_MAX_X_DEF,
  parameter int GRID_MAX_Y = gtsg_pkg::GRID_MAX_Y_DEF,
  parameter int GRID_MAX_Z = gtsg_pkg::GRID_MAX_Z_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // cell_x, cell_y, cell_z, sample_value, pos_x, pos_y, pos_z, zero pad
  input  wire logic [gtsg_pkg::S_TDATA_W-1:0]   s_tdata,
  // func
  input  wire logic                             s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // value, grad_x, grad_y, grad_z, zero pad
  output logic      [gtsg_pkg::M_TDATA_W-1:0]   m_tdata,
  // out_of_range
  output logic                                  m_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [gtsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gtsg_pkg::CFG_W-1:0]       cfg_data
);

  import gtsg_pkg::*;

  localparam int AXW = $clog2(GRID_MAX_X);
  localparam int AYW = $clog2(GRID_MAX_Y);
  localparam int AZW = $clog2(GRID_MAX_Z);
  localparam int AW  = AXW + AYW + AZW;

  // Arithmetic helpers; every floor is an arithmetic right shift.
  function automatic logic signed [23:0] lerp_s(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [7:0] f);
    logic signed [16:0] d;
    logic signed [8:0]  fs;
    logic signed [25:0] p;
    logic signed [25:0] r;
    d  = 17'(b) - 17'(a);
    fs = $signed({1'b0, f});
    p  = 26'(d) * 26'(fs);
    r  = 26'(a);
    r  = (r <<< FRAC_BITS) + p;
    return r[23:0];
  endfunction

  function automatic logic signed [23:0] lerp_w(input logic signed [23:0] a,
                                                input logic signed [23:0] b,
                                                input logic [7:0] f);
    logic signed [24:0] d;
    logic signed [8:0]  fs;
    logic signed [33:0] p;
    logic signed [33:0] r;
    d  = 25'(b) - 25'(a);
    fs = $signed({1'b0, f});
    p  = 34'(d) * 34'(fs);
    r  = 34'(a) + (p >>> FRAC_BITS);
    return r[23:0];
  endfunction

  function automatic logic signed [27:0] mul_f(input logic signed [18:0] v,
                                               input logic [7:0] f);
    logic signed [8:0]  fs;
    logic signed [27:0] p;
    fs = $signed({1'b0, f});
    p  = 28'(v) * 28'(fs);
    return p;
  endfunction

  function automatic logic signed [28:0] mul_ff(input logic signed [27:0] v,
                                                input logic [7:0] f);
    logic signed [8:0]  fs;
    logic signed [36:0] p;
    fs = $signed({1'b0, f});
    p  = 37'(v) * 37'(fs);
    p  = p >>> FRAC_BITS;
    return p[28:0];
  endfunction

  function automatic logic signed [24:0] grad_sum(input logic signed [16:0] v,
                                                  input logic signed [27:0] a,
                                                  input logic signed [27:0] b,
                                                  input logic signed [28:0] q);
    logic signed [30:0] r;
    r = 31'(v);
    r = (r <<< FRAC_BITS) + 31'(a) + 31'(b) + 31'(q);
    return r[24:0];
  endfunction

  // Input word fields.
  logic [CELL_W-1:0]   cell_x, cell_y, cell_z;
  logic [SAMPLE_W-1:0] sample_value;
  logic [POS_W-1:0]    pos_x, pos_y, pos_z;

  assign cell_x       = s_tdata[4:0];
  assign cell_y       = s_tdata[9:5];
  assign cell_z       = s_tdata[14:10];
  assign sample_value = s_tdata[30:15];
  assign pos_x        = s_tdata[43:31];
  assign pos_y        = s_tdata[56:44];
  assign pos_z        = s_tdata[69:57];

  // Configuration registers.
  logic [CFG_W-1:0] grid_width, grid_height, grid_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_SIZE_RESET;
      grid_height <= CFG_SIZE_RESET;
      grid_depth  <= CFG_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_GRID_DEPTH:  grid_depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Range check on the query word as it arrives.
  logic [8:0] size_x, size_y, size_z;
  logic       in_range;
  logic       write_ok;

  always_comb begin
    size_x = (9'(grid_width)  > 9'(GRID_MAX_X)) ? 9'(GRID_MAX_X) : 9'(grid_width);
    size_y = (9'(grid_height) > 9'(GRID_MAX_Y)) ? 9'(GRID_MAX_Y) : 9'(grid_height);
    size_z = (9'(grid_depth)  > 9'(GRID_MAX_Z)) ? 9'(GRID_MAX_Z) : 9'(grid_depth);
    in_range = ((9'(pos_x[POS_W-1:FRAC_BITS]) + 9'd2) <= size_x) &&
               ((9'(pos_y[POS_W-1:FRAC_BITS]) + 9'd2) <= size_y) &&
               ((9'(pos_z[POS_W-1:FRAC_BITS]) + 9'd2) <= size_z);
    write_ok = (9'(cell_x) < 9'(GRID_MAX_X)) && (9'(cell_y) < 9'(GRID_MAX_Y)) &&
               (9'(cell_z) < 9'(GRID_MAX_Z));
  end

  // Sequencer.
  gtsg_state_t state, state_next;
  logic [2:0]  cnt;
  logic        accept;
  logic        out_free;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic [AXW-1:0] ix;
  logic [AYW-1:0] iy;
  logic [AZW-1:0] iz;
  logic [FRAC_BITS-1:0] fx, fy, fz;
  logic oor;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    // The store is laid out as {z, y, x}; corner k sits at offset {k[2], k[1], k[0]}.
    ram_addr   = {AZW'(iz + AZW'(cnt[2])), AYW'(iy + AYW'(cnt[1])),
                  AXW'(ix + AXW'(cnt[0]))};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == FUNC_WRITE) begin
            ram_we   = write_ok;
            ram_addr = {AZW'(cell_z), AYW'(cell_y), AXW'(cell_x)};
          end else if (in_range) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        if (cnt == 3'd7) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_PROD;
      ST_PROD: state_next = ST_MIX;
      ST_MIX:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  gtsg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (2 ** AW)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample_value),
    .rdata (ram_rdata)
  );

  // Read counter and corner capture, in the cycle after the address.
  logic       cap_vld;
  logic [2:0] cap_idx;
  logic signed [SAMPLE_W-1:0] corner [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= 3'd0;
      cap_vld <= 1'b0;
    end else begin
      cap_vld <= (state == ST_READ);
      if (accept) begin
        cnt <= 3'd0;
      end else if (state == ST_READ) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_idx <= cnt;
    if (cap_vld) begin
      corner[cap_idx] <= $signed(ram_rdata);
    end
    if (accept) begin
      ix  <= AXW'(pos_x[POS_W-1:FRAC_BITS]);
      iy  <= AYW'(pos_y[POS_W-1:FRAC_BITS]);
      iz  <= AZW'(pos_z[POS_W-1:FRAC_BITS]);
      fx  <= pos_x[FRAC_BITS-1:0];
      fy  <= pos_y[FRAC_BITS-1:0];
      fz  <= pos_z[FRAC_BITS-1:0];
      oor <= !in_range;
    end
  end

  // Arithmetic steps over the captured corners.
  logic signed [18:0] v0;
  logic signed [17:0] v1, v2, v4;
  logic signed [16:0] v3, v5, v6;
  logic signed [23:0] b0, b1, t0, t1, bm, tm;
  logic signed [27:0] p_v4fy, p_v2fz, p_v0fy, p_v4fx, p_v1fz, p_v0fx, p_v2fx, p_v1fy;
  logic signed [28:0] q_x, q_y, q_z;

  always_ff @(posedge clk) begin
    case (state)
      ST_DIFF: begin
        v0 <= 19'(corner[2]) - 19'(corner[3]) + 19'(corner[7]) - 19'(corner[6])
              + 19'(corner[1]) - 19'(corner[5]) + 19'(corner[4]) - 19'(corner[0]);
        v1 <= -18'(corner[2]) + 18'(corner[6]) - 18'(corner[4]) + 18'(corner[0]);
        v2 <= -18'(corner[1]) + 18'(corner[5]) - 18'(corner[4]) + 18'(corner[0]);
        v3 <= 17'(corner[4]) - 17'(corner[0]);
        v4 <= -18'(corner[2]) + 18'(corner[3]) - 18'(corner[1]) + 18'(corner[0]);
        v5 <= 17'(corner[2]) - 17'(corner[0]);
        v6 <= 17'(corner[1]) - 17'(corner[0]);
      end
      ST_PROD: begin
        b0     <= lerp_s(corner[0], corner[1], fx);
        b1     <= lerp_s(corner[4], corner[5], fx);
        t0     <= lerp_s(corner[2], corner[3], fx);
        t1     <= lerp_s(corner[6], corner[7], fx);
        p_v4fy <= mul_f(19'(v4), fy);
        p_v2fz <= mul_f(19'(v2), fz);
        p_v0fy <= mul_f(v0, fy);
        p_v4fx <= mul_f(19'(v4), fx);
        p_v1fz <= mul_f(19'(v1), fz);
        p_v0fx <= mul_f(v0, fx);
        p_v2fx <= mul_f(19'(v2), fx);
        p_v1fy <= mul_f(19'(v1), fy);
      end
      ST_MIX: begin
        bm  <= lerp_w(b0, b1, fz);
        tm  <= lerp_w(t0, t1, fz);
        q_x <= mul_ff(p_v0fy, fz);
        q_y <= mul_ff(p_v0fx, fz);
        q_z <= mul_ff(p_v0fx, fy);
      end
      default: ;
    endcase
  end

  // Final step feeds the output register directly.
  logic signed [23:0] value;
  logic signed [24:0] grad_x, grad_y, grad_z;

  always_comb begin
    value  = lerp_w(bm, tm, fy);
    grad_x = grad_sum(v6, p_v4fy, p_v2fz, q_x);
    grad_y = grad_sum(v5, p_v4fx, p_v1fz, q_y);
    grad_z = grad_sum(v3, p_v2fx, p_v1fy, q_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tuser <= oor;
      if (oor) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {5'd0, grad_z, grad_y, grad_x, value};
      end
    end
  end

`ifndef SYNTHESIS
  a_cap_window: assert property (@(posedge clk) disable iff (rst)
    cap_vld |-> $past(state) == ST_READ)
    else $error("corner captured outside the read window");

  a_read_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && cnt == 3'd7) |=> state == ST_LAST)
    else $error("read window did not end after eight corners");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> state == ST_DONE)
    else $error("result left while the output register was full");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata == '0)
    else $error("out-of-range result carries nonzero data");

  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE && accept && s_tuser == FUNC_WRITE))
    else $error("grid write outside an accepted write word");
`endif

endmodule : grid_trilinear_sample_gradient_core

`default_nettype wire

// ----- src/gtsg_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none

module gtsg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : gtsg_ram

`default_nettype wire
